// File: hw/rtl/mpb_pkg.sv
// Shared types and constants for the MCU pixel blitter.
// No dependencies; every other file of the block imports this package.
package mpb_pkg;

  // Image dimension limits and screen geometry.
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned MAX_IMAGE_DIM = 4096;
  localparam int unsigned SCREEN_LINES  = 512;
  localparam int unsigned COLS_NARROW   = 512;
  localparam int unsigned COLS_WIDE     = 768;
  localparam int unsigned PITCH_SH_NAR  = 9;   // pitch 512
  localparam int unsigned PITCH_SH_WIDE = 10;  // pitch 1024

  // Field widths.
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned ADDR_W   = 19;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Counter widths.
  localparam int unsigned MCU_COL_W = 9;
  localparam int unsigned MCU_ROW_W = 10;
  localparam int unsigned BLK_W     = 2;
  localparam int unsigned PIX_W     = 6;
  localparam int unsigned POS_W     = 14;  // image row/column inside the MCU grid

  // floor(v * b / 800) == (v * b * BRIGHT_MULT) >> BRIGHT_SHIFT for all v*b < 2^15.
  // The scale (v*32*b/100)>>8 collapses to floor(v*b/800).
  localparam int unsigned BRIGHT_MULT  = 41944;
  localparam int unsigned BRIGHT_SHIFT = 25;
  localparam int unsigned BMUL_W       = 23;
  localparam int unsigned PROD_W       = CHAN_W + BMUL_W;
  localparam int unsigned BRIGHT_RESET = 100;

  // Stream payload widths.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_MCU_WIDE     = 3'd2,
    CFG_MCU_TALL     = 3'd3,
    CFG_BRIGHTNESS   = 3'd4,
    CFG_HALVE        = 3'd5,
    CFG_WIDE_SCREEN  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic              mcu_wide;
    logic              mcu_tall;
    logic              halve;         // keep only even rows and columns
    logic              wide_screen;
    logic [BMUL_W-1:0] bright_mult;   // brightness * BRIGHT_MULT
  } cfg_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic              last_pixel;
  } pos_res_t;

endpackage

// File: hw/rtl/mpb_cfg_regs.sv
// Configuration register file of the MCU pixel blitter.
// Depends on mpb_pkg; the brightness factor is pre-multiplied on write.
module mpb_cfg_regs
  import mpb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i[DIM_W-1:0];
        CFG_MCU_WIDE:     cfg_d.mcu_wide     = cfg_data_i[0];
        CFG_MCU_TALL:     cfg_d.mcu_tall     = cfg_data_i[0];
        CFG_BRIGHTNESS:   cfg_d.bright_mult  = BMUL_W'(cfg_data_i[BRIGHT_W-1:0] *
                                               BMUL_W'(BRIGHT_MULT));
        CFG_HALVE:        cfg_d.halve        = cfg_data_i[0];
        CFG_WIDE_SCREEN:  cfg_d.wide_screen  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= DIM_W'(512);
      cfg_q.image_height <= DIM_W'(512);
      cfg_q.mcu_wide     <= 1'b0;
      cfg_q.mcu_tall     <= 1'b0;
      cfg_q.halve        <= 1'b0;
      cfg_q.wide_screen  <= 1'b0;
      cfg_q.bright_mult  <= BMUL_W'(BRIGHT_RESET * BRIGHT_MULT);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/mpb_addr_gen.sv
// MCU position counters and framebuffer address generation with clipping.
// Depends on mpb_pkg; counters advance per in-frame pixel leaving the input stage.
module mpb_addr_gen
  import mpb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     step_i,         // current pixel moves to the result register
  input  logic     frame_start_i,
  output pos_res_t res_o
);

  logic [MCU_COL_W-1:0] col_q, col_d, cur_col;
  logic [MCU_ROW_W-1:0] row_q, row_d, cur_row;
  logic [BLK_W-1:0]     blk_q, blk_d, cur_blk;
  logic [PIX_W-1:0]     pix_q, pix_d, cur_pix;

  logic [DIM_W-1:0]     w_eff, h_eff, w_round, h_round, iw, ih;
  logic [MCU_ROW_W-1:0] per_row, per_col;
  logic [2:0]           nblocks;
  logic                 active, keep, on_screen, last_blk, last_col, last_row;
  logic [2:0]           xoff, yoff_sel;
  logic [3:0]           xoff4, yoff4;
  logic [POS_W-1:0]     img_col, img_row, col_h, row_h;
  logic [9:0]           cols;
  logic signed [15:0]   dx, dy, dx_adj, dy_adj, xo, yo, gx, gy;
  logic [ADDR_W-1:0]    gx_u, gy_u, addr;

  // Image size clamped to 1..MAX_IMAGE_DIM.
  always_comb begin
    w_eff = cfg_i.image_width;
    if (cfg_i.image_width == '0) w_eff = DIM_W'(1);
    else if (cfg_i.image_width > DIM_W'(MAX_IMAGE_DIM)) w_eff = DIM_W'(MAX_IMAGE_DIM);
    h_eff = cfg_i.image_height;
    if (cfg_i.image_height == '0) h_eff = DIM_W'(1);
    else if (cfg_i.image_height > DIM_W'(MAX_IMAGE_DIM)) h_eff = DIM_W'(MAX_IMAGE_DIM);
  end

  always_comb begin
    w_round = w_eff + (cfg_i.mcu_wide ? DIM_W'(15) : DIM_W'(7));
    h_round = h_eff + (cfg_i.mcu_tall ? DIM_W'(15) : DIM_W'(7));
    per_row = cfg_i.mcu_wide ? MCU_ROW_W'(w_round >> 4) : MCU_ROW_W'(w_round >> 3);
    per_col = cfg_i.mcu_tall ? MCU_ROW_W'(h_round >> 4) : MCU_ROW_W'(h_round >> 3);
    case ({cfg_i.mcu_wide, cfg_i.mcu_tall})
      2'b11:   nblocks = 3'd4;
      2'b10,
      2'b01:   nblocks = 3'd2;
      default: nblocks = 3'd1;
    endcase
  end

  // A frame start clears the position before this pixel is placed.
  assign cur_col = frame_start_i ? '0 : col_q;
  assign cur_row = frame_start_i ? '0 : row_q;
  assign cur_blk = frame_start_i ? '0 : blk_q;
  assign cur_pix = frame_start_i ? '0 : pix_q;

  assign active = cur_row < per_col;

  always_comb begin
    xoff4 = (cfg_i.mcu_wide && cur_blk[0]) ? 4'd8 : 4'd0;
    yoff_sel = {2'b00, cfg_i.mcu_wide ? cur_blk[1] : cur_blk[0]};
    yoff4 = (cfg_i.mcu_tall && yoff_sel[0]) ? 4'd8 : 4'd0;
    xoff = cur_pix[2:0];
    img_col = (cfg_i.mcu_wide ? (POS_W'(cur_col) << 4) : (POS_W'(cur_col) << 3))
              + POS_W'(xoff4) + POS_W'(xoff);
    img_row = (cfg_i.mcu_tall ? (POS_W'(cur_row) << 4) : (POS_W'(cur_row) << 3))
              + POS_W'(yoff4) + POS_W'(cur_pix[5:3]);
    keep = (img_col < POS_W'(w_eff)) && (img_row < POS_W'(h_eff))
           && !(cfg_i.halve && (cur_pix[0] || cur_pix[3]));
  end

  // Centering offsets, truncated toward zero like a signed divide by two.
  always_comb begin
    cols  = cfg_i.wide_screen ? 10'(COLS_WIDE) : 10'(COLS_NARROW);
    iw    = cfg_i.halve ? (w_eff >> 1) : w_eff;
    ih    = cfg_i.halve ? (h_eff >> 1) : h_eff;
    col_h = cfg_i.halve ? (img_col >> 1) : img_col;
    row_h = cfg_i.halve ? (img_row >> 1) : img_row;
    dx     = $signed(16'(cols)) - $signed(16'(iw));
    dy     = $signed(16'(SCREEN_LINES)) - $signed(16'(ih));
    dx_adj = dx + $signed({15'd0, dx[15]});
    dy_adj = dy + $signed({15'd0, dy[15]});
    xo     = dx_adj >>> 1;
    yo     = dy_adj >>> 1;
    gx     = xo + $signed({2'b00, col_h});
    gy     = yo + $signed({2'b00, row_h});
    on_screen = !gx[15] && (gx < $signed(16'(cols)))
                && !gy[15] && (gy < $signed(16'(SCREEN_LINES)));
    gx_u = ADDR_W'(unsigned'(gx));
    gy_u = ADDR_W'(unsigned'(gy));
    addr = (cfg_i.wide_screen ? (gy_u << PITCH_SH_WIDE) : (gy_u << PITCH_SH_NAR)) + gx_u;
  end

  always_comb begin
    last_blk = (3'(cur_blk) + 3'd1) >= nblocks;
    last_col = (MCU_ROW_W'(cur_col) + MCU_ROW_W'(1)) >= per_row;
    last_row = (11'(cur_row) + 11'd1) >= 11'(per_col);
  end

  always_comb begin
    res_o.write_enable  = active && keep && on_screen;
    res_o.write_address = (active && keep && on_screen) ? addr : '0;
    res_o.last_pixel    = active && (cur_pix == '1) && last_blk && last_col && last_row;
  end

  // Position update: pixel, then block, then MCU column and row.
  always_comb begin
    col_d = cur_col;
    row_d = cur_row;
    blk_d = cur_blk;
    pix_d = cur_pix;
    if (active) begin
      if (cur_pix != '1) begin
        pix_d = cur_pix + PIX_W'(1);
      end else begin
        pix_d = '0;
        if (!last_blk) begin
          blk_d = cur_blk + BLK_W'(1);
        end else begin
          blk_d = '0;
          if (last_col) begin
            col_d = '0;
            row_d = cur_row + MCU_ROW_W'(1);
          end else begin
            col_d = cur_col + MCU_COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      blk_q <= '0;
      pix_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
      blk_q <= blk_d;
      pix_q <= pix_d;
    end
  end

endmodule

// File: hw/rtl/mpb_color_scale.sv
// Brightness scaling of a pixel to 5 bits per channel, packed {G,R,B,opaque}.
// Depends on mpb_pkg; one multiplier per channel against the pre-scaled factor.
module mpb_color_scale
  import mpb_pkg::*;
(
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  logic [BMUL_W-1:0] bright_mult_i,
  output logic [WORD_W-1:0] pixel_word_o
);

  function automatic logic [4:0] scale5(input logic [CHAN_W-1:0] v,
                                        input logic [BMUL_W-1:0] m);
    logic [PROD_W-1:0] prod;
    logic [5:0]        q;
    prod = PROD_W'(v) * PROD_W'(m);
    q = prod[BRIGHT_SHIFT +: 6];
    scale5 = (q > 6'd31) ? 5'd31 : q[4:0];
  endfunction

  assign pixel_word_o = {scale5(green_i, bright_mult_i), scale5(red_i, bright_mult_i),
                         scale5(blue_i, bright_mult_i), 1'b1};

endmodule

// File: hw/rtl/mcu_pixel_blit_rgb555.sv
// Top level of the MCU pixel blitter: input register, address and colour logic,
// result register. Depends on mpb_pkg, mpb_cfg_regs, mpb_addr_gen, mpb_color_scale.
//
//  channel   direction  transfer condition             payload
//  s_axis    in         s_axis_tvalid & s_axis_tready  tdata {blue,green,red}, tuser frame_start
//  m_axis    out        m_axis_tvalid & m_axis_tready  tdata {word,address}, tuser write_enable,
//                                                      tlast last_pixel
//  cfg       in         cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// One pixel per clock is sustained while m_axis_tready stays high; each pixel passes through
// the input register and then the result register. The position counters and the three
// brightness multipliers sit between these two registers.
// Reset clears the valid flags, the position counters and the configuration to its defaults.
// A stall on m_axis holds the result register; the input register still takes one more
// transfer, and s_axis_tready drops only when both registers are full.
module mcu_pixel_blit_rgb555
  import mpb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel input.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic                  s_axis_tuser,   // [0] frame_start
  // Framebuffer writes.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [18:0] write_address, [34:19] pixel_word,
                                                // [39:35] zero
  output logic                  m_axis_tuser,   // [0] write_enable
  output logic                  m_axis_tlast,   // last_pixel
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t     cfg;
  pos_res_t pos_res;

  logic                 in_valid_q;
  logic                 in_fs_q;
  logic [CHAN_W-1:0]    in_red_q, in_green_q, in_blue_q;
  logic                 out_valid_q;
  logic                 out_we_q, out_last_q;
  logic [ADDR_W-1:0]    out_addr_q;
  logic [WORD_W-1:0]    out_word_q, word;
  logic                 out_free, step, s_xfer;

  // Configuration is always accepted; the host must write it only while the block is idle.
  assign cfg_ready_o = 1'b1;

  mpb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register is free when empty or when its content leaves this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_fs_q    <= s_axis_tuser;
      in_red_q   <= s_axis_tdata[7:0];
      in_green_q <= s_axis_tdata[15:8];
      in_blue_q  <= s_axis_tdata[23:16];
    end
  end

  mpb_addr_gen u_addr_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .step_i        (step),
    .frame_start_i (in_fs_q),
    .res_o         (pos_res)
  );

  mpb_color_scale u_color_scale (
    .red_i         (in_red_q),
    .green_i       (in_green_q),
    .blue_i        (in_blue_q),
    .bright_mult_i (cfg.bright_mult),
    .pixel_word_o  (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Clipped pixels carry a zero address and a zero colour word.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_we_q   <= pos_res.write_enable;
      out_addr_q <= pos_res.write_address;
      out_word_q <= pos_res.write_enable ? word : '0;
      out_last_q <= pos_res.last_pixel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_word_q, out_addr_q};
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hw/rtl/mpb_port_checker.sv
// Port-level assertions for the MCU pixel blitter and their bind to the top level.
// Depends on mpb_pkg for the stream and address widths.
module mpb_port_checker
  import mpb_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An empty result register never blocks the input side.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // Clipped pixels carry an all-zero payload.
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("clipped pixel with nonzero payload");

  // Written pixels carry the opaque bit of the colour word and zero upper bits.
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[ADDR_W] && m_axis_tdata[M_TDATA_W-1:35] == '0)
    else $error("written pixel without opaque bit");

endmodule

bind mcu_pixel_blit_rgb555 mpb_port_checker u_mpb_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
